FILE: hdl/jdbs_pkg.sv
// shared types and constants of the json document boundary scanner
package jdbs_pkg;

    localparam int DEPTH_BITS = 16;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);
    localparam int Q_CW       = $clog2(Q_DEPTH + 1);

    typedef logic signed [DEPTH_BITS-1:0] t_depth;

    localparam t_depth DEPTH_MAX = t_depth'({1'b0, {(DEPTH_BITS-1){1'b1}}});
    localparam t_depth DEPTH_MIN = t_depth'({1'b1, {(DEPTH_BITS-1){1'b0}}});

    typedef enum logic [3:0] {
        CLS_OTHER,
        CLS_NUL,
        CLS_QUOTE,
        CLS_BSLASH,
        CLS_EOL,
        CLS_OPEN_BRACE,
        CLS_CLOSE_BRACE,
        CLS_OPEN_BRACKET,
        CLS_CLOSE_BRACKET
    } t_cls;

    typedef struct packed {
        t_cls cls;
        logic last;
        logic empty;
    } t_entry;

endpackage

FILE: hdl/jdbs_front.sv
// front end: accepts requests and classifies each byte
module jdbs_front (
    input  logic            i_valid,
    input  logic [7:0]      i_data_byte,
    input  logic            i_end_of_buffer,
    input  logic            i_empty_buffer,
    input  logic            i_q_full,
    output logic            o_stall,
    output logic            o_push,
    output jdbs_pkg::t_entry o_entry
);
    import jdbs_pkg::*;

    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5c;
    localparam logic [7:0] CH_LF       = 8'h0a;
    localparam logic [7:0] CH_CR       = 8'h0d;
    localparam logic [7:0] CH_LBRACE   = 8'h7b;
    localparam logic [7:0] CH_RBRACE   = 8'h7d;
    localparam logic [7:0] CH_LBRACKET = 8'h5b;
    localparam logic [7:0] CH_RBRACKET = 8'h5d;

    t_cls cls;

    always_comb begin
        case (i_data_byte)
            CH_NUL:      cls = CLS_NUL;
            CH_QUOTE:    cls = CLS_QUOTE;
            CH_BSLASH:   cls = CLS_BSLASH;
            CH_LF,
            CH_CR:       cls = CLS_EOL;
            CH_LBRACE:   cls = CLS_OPEN_BRACE;
            CH_RBRACE:   cls = CLS_CLOSE_BRACE;
            CH_LBRACKET: cls = CLS_OPEN_BRACKET;
            CH_RBRACKET: cls = CLS_CLOSE_BRACKET;
            default:     cls = CLS_OTHER;
        endcase
    end

    assign o_stall       = i_q_full;
    assign o_push        = i_valid && !i_q_full;
    assign o_entry.cls   = cls;
    assign o_entry.last  = i_end_of_buffer;
    assign o_entry.empty = i_empty_buffer;

endmodule

FILE: hdl/jdbs_queue.sv
// short fifo of classified requests between front and back
module jdbs_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  jdbs_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output jdbs_pkg::t_entry o_head
);
    import jdbs_pkg::*;

    t_entry            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CW-1:0]   r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

endmodule

FILE: hdl/jdbs_back.sv
// back end: depth counters, string and skip flags, result register
module jdbs_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  jdbs_pkg::t_entry i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_has_document
);
    import jdbs_pkg::*;

    t_depth r_brace, n_brace;
    t_depth r_bracket, n_bracket;
    logic   r_in_str, n_in_str;
    logic   r_skip, n_skip;
    logic   r_seen, n_seen;
    logic   r_answered, n_answered;
    logic   r_out_valid;
    logic   r_out_doc;

    logic   produce, ans, done, clear, out_free;

    function automatic t_depth depth_inc(input t_depth v);
        return (v == DEPTH_MAX) ? v : v + t_depth'(1);
    endfunction

    function automatic t_depth depth_dec(input t_depth v);
        return (v == DEPTH_MIN) ? v : v - t_depth'(1);
    endfunction

    always_comb begin
        n_brace    = r_brace;
        n_bracket  = r_bracket;
        n_in_str   = r_in_str;
        n_skip     = r_skip;
        n_seen     = r_seen;
        n_answered = r_answered;
        produce    = 1'b0;
        ans        = 1'b0;
        done       = 1'b0;
        clear      = 1'b0;
        if (i_head.empty) begin
            produce = 1'b1;
            ans     = 1'b1;
            clear   = 1'b1;
        end else if (r_answered) begin
            clear = i_head.last;
        end else begin
            if (r_skip) begin
                n_skip = 1'b0;
            end else begin
                case (i_head.cls)
                    CLS_NUL: begin
                        done = 1'b1;
                        ans  = r_seen && (r_brace == '0) && (r_bracket == '0);
                    end
                    CLS_QUOTE:  n_in_str = !r_in_str;
                    CLS_BSLASH: n_skip = 1'b1;
                    CLS_EOL: begin
                        if (!r_in_str) begin
                            done = 1'b1;
                            ans  = r_seen && (r_brace == '0) && (r_bracket == '0);
                        end
                    end
                    CLS_OPEN_BRACE:    if (!r_in_str) n_brace = depth_inc(r_brace);
                    CLS_CLOSE_BRACE:   if (!r_in_str) n_brace = depth_dec(r_brace);
                    CLS_OPEN_BRACKET:  if (!r_in_str) n_bracket = depth_inc(r_bracket);
                    CLS_CLOSE_BRACKET: if (!r_in_str) n_bracket = depth_dec(r_bracket);
                    default: ;
                endcase
            end
            n_seen = 1'b1;
            // buffer ran out without a terminator
            if (!done && i_head.last) begin
                done = 1'b1;
                ans  = (n_brace == '0) && (n_bracket == '0);
            end
            produce = done;
            if (done) begin
                if (i_head.last) begin
                    clear = 1'b1;
                end else begin
                    n_answered = 1'b1;
                end
            end
        end
        if (clear) begin
            n_brace    = '0;
            n_bracket  = '0;
            n_in_str   = 1'b0;
            n_skip     = 1'b0;
            n_seen     = 1'b0;
            n_answered = 1'b0;
        end
    end

    assign out_free = !r_out_valid || !i_stall;
    // requests with no result go on even while the result slot is held
    assign o_pop    = i_q_valid && (!produce || out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brace     <= '0;
            r_bracket   <= '0;
            r_in_str    <= 1'b0;
            r_skip      <= 1'b0;
            r_seen      <= 1'b0;
            r_answered  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_brace    <= n_brace;
                r_bracket  <= n_bracket;
                r_in_str   <= n_in_str;
                r_skip     <= n_skip;
                r_seen     <= n_seen;
                r_answered <= n_answered;
            end
            if (o_pop && produce) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && produce) begin
            r_out_doc <= ans;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_has_document = r_out_doc;

`ifndef SYNTHESIS
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_pop |=> $stable({r_brace, r_bracket, r_in_str, r_skip, r_seen, r_answered}))
        else $error("scan state changed without a request");

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && produce |=> r_out_valid)
        else $error("result lost on its way to the output register");

    a_answered_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_answered |-> r_seen && !r_skip)
        else $error("answer flag set with inconsistent scan flags");

    a_hold_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid && !o_pop |-> produce && r_out_valid && i_stall)
        else $error("queue head held with the result slot free");
`endif

endmodule

FILE: hdl/json_document_boundary_scanner.sv
// top level of the json document boundary scanner
//
//  channel  direction  handshake          payload
//  input    in         i_valid / o_stall  i_data_byte, i_end_of_buffer, i_empty_buffer
//  output   out        o_valid / i_stall  o_has_document
//
// one byte a cycle sustained while the queue has room; each depth and flag update is made in the back end
// a taken byte is held in the queue, then its result is held in the result register
// synchronous active-low reset clears queue, scan state and result valid
// output stalls only hold bytes that yield a result; others drain past a held result
// a four-deep queue lets the input run on until it fills
module json_document_boundary_scanner (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_buffer,
    input  logic       i_empty_buffer,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_has_document
);
    import jdbs_pkg::*;

    logic   q_full, q_valid, push, pop;
    t_entry push_entry, head;

    jdbs_front u_front (
        .i_valid         (i_valid),
        .i_data_byte     (i_data_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .i_empty_buffer  (i_empty_buffer),
        .i_q_full        (q_full),
        .o_stall         (o_stall),
        .o_push          (push),
        .o_entry         (push_entry)
    );

    jdbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head)
    );

    jdbs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_head         (head),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_has_document (o_has_document)
    );

endmodule

FILE: verif/jdbs_scan_checker.sv
// byte constants, result predictor and result checker for the boundary scanner bench
`timescale 1ns / 100ps

package jdbs_tb_chars;

    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_DIGIT0   = 8'h30;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;

endpackage

module jdbs_scan_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_buffer,
    input  logic       i_empty_buffer,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic       i_has_document,
    output int         o_fail_count,
    output int         o_pending
);
    import jdbs_pkg::*;
    import jdbs_tb_chars::*;

    t_depth brace_lvl;
    t_depth bracket_lvl;
    logic   in_str;
    logic   skip_byte;
    logic   seen_byte;
    logic   answered;
    logic   expected_docs[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        o_fail_count++;
    endtask

    task automatic clear_scan();
        brace_lvl   = '0;
        bracket_lvl = '0;
        in_str      = 1'b0;
        skip_byte   = 1'b0;
        seen_byte   = 1'b0;
        answered    = 1'b0;
    endtask

    function automatic logic balanced();
        return brace_lvl == 0 && bracket_lvl == 0;
    endfunction

    // next scan state for one request; answer is valid only when produces is set
    task automatic scan_byte(input logic [7:0] b, input logic last, input logic empty,
                             output logic produces, output logic answer);
        logic ends;
        ends     = 1'b0;
        produces = 1'b0;
        answer   = 1'b0;
        if (empty) begin
            clear_scan();
            produces = 1'b1;
            answer   = 1'b1;
        end else if (answered) begin
            if (last) clear_scan();
        end else begin
            if (skip_byte) begin
                skip_byte = 1'b0;
            end else begin
                case (b)
                    CH_NUL: begin
                        ends   = 1'b1;
                        answer = seen_byte && balanced();
                    end
                    CH_QUOTE:  in_str = !in_str;
                    CH_BSLASH: skip_byte = 1'b1;
                    CH_LF, CH_CR: begin
                        if (!in_str) begin
                            ends   = 1'b1;
                            answer = seen_byte && balanced();
                        end
                    end
                    CH_LBRACE: begin
                        if (!in_str && brace_lvl != DEPTH_MAX)
                            brace_lvl = brace_lvl + t_depth'(1);
                    end
                    CH_RBRACE: begin
                        if (!in_str && brace_lvl != DEPTH_MIN)
                            brace_lvl = brace_lvl - t_depth'(1);
                    end
                    CH_LBRACKET: begin
                        if (!in_str && bracket_lvl != DEPTH_MAX)
                            bracket_lvl = bracket_lvl + t_depth'(1);
                    end
                    CH_RBRACKET: begin
                        if (!in_str && bracket_lvl != DEPTH_MIN)
                            bracket_lvl = bracket_lvl - t_depth'(1);
                    end
                    default: ;
                endcase
            end
            seen_byte = 1'b1;
            if (!ends && last) begin
                ends   = 1'b1;
                answer = balanced();
            end
            if (ends) begin
                produces = 1'b1;
                if (last) clear_scan();
                else answered = 1'b1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        logic produces;
        logic answer;
        logic want;
        if (!i_rst_n) begin
            clear_scan();
            expected_docs.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                scan_byte(i_data_byte, i_end_of_buffer, i_empty_buffer, produces, answer);
                if (produces) expected_docs.push_back(answer);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_docs.size() == 0) begin
                    report_mismatch($sformatf("result has_document=%b with none expected",
                                              i_has_document));
                end else begin
                    want = expected_docs.pop_front();
                    if (i_has_document !== want)
                        report_mismatch($sformatf("has_document=%b, expected %b",
                                                  i_has_document, want));
                end
            end
        end
        o_pending <= expected_docs.size();
    end

endmodule

FILE: verif/json_document_boundary_scanner_test.sv
// top of the boundary scanner bench: clock, reset, request stimulus and verdict
`timescale 1ns / 100ps

module json_document_boundary_scanner_test;
    import jdbs_tb_chars::*;

    localparam int ITEM_TARGET = 1900;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_valid         = 1'b0;
    logic [7:0] i_data_byte     = '0;
    logic       i_end_of_buffer = 1'b0;
    logic       i_empty_buffer  = 1'b0;
    logic       i_stall         = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_has_document;

    int         fail_count;
    int         pending_docs;
    int         item_count = 0;
    int         stall_left = 0;
    logic       quiet      = 1'b0;
    logic [7:0] pend_bytes[$];

    json_document_boundary_scanner uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .i_empty_buffer  (i_empty_buffer),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_has_document  (o_has_document)
    );

    jdbs_scan_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .i_empty_buffer  (i_empty_buffer),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_has_document  (o_has_document),
        .o_fail_count    (fail_count),
        .o_pending       (pending_docs)
    );

    always #4 i_clk = ~i_clk;

    // result-side back-pressure in random bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 15);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic send_req(input logic [7:0] b, input logic last, input logic empty);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_data_byte     <= b;
        i_end_of_buffer <= last;
        i_empty_buffer  <= empty;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        item_count++;
    endtask

    // now and then an empty-buffer request cuts into the buffer
    task automatic send_buffer();
        for (int i = 0; i < pend_bytes.size(); i++) begin
            if ($urandom_range(0, 199) == 0)
                send_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            send_req(pend_bytes[i], i == pend_bytes.size() - 1, 1'b0);
        end
        pend_bytes.delete();
    endtask

    function automatic logic [7:0] pick_noise();
        case ($urandom_range(0, 11))
            0:       return CH_NUL;
            1:       return CH_QUOTE;
            2:       return CH_BSLASH;
            3:       return CH_LF;
            4:       return CH_CR;
            5:       return CH_LBRACE;
            6:       return CH_RBRACE;
            7:       return CH_LBRACKET;
            8:       return CH_RBRACKET;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_terminator();
        case ($urandom_range(0, 2))
            0:       return CH_LF;
            1:       return CH_CR;
            default: return CH_NUL;
        endcase
    endfunction

    // string body holds escapes, structural characters and line breaks
    task automatic add_string();
        pend_bytes.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 7))
                0: begin
                    pend_bytes.push_back(CH_BSLASH);
                    pend_bytes.push_back(8'($urandom_range(0, 255)));
                end
                1: begin
                    case ($urandom_range(0, 3))
                        0:       pend_bytes.push_back(CH_LBRACE);
                        1:       pend_bytes.push_back(CH_RBRACE);
                        2:       pend_bytes.push_back(CH_LBRACKET);
                        default: pend_bytes.push_back(CH_RBRACKET);
                    endcase
                end
                2: pend_bytes.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
                default: pend_bytes.push_back(8'($urandom_range(8'h23, 8'h5B)));
            endcase
        end
        pend_bytes.push_back(CH_QUOTE);
    endtask

    task automatic add_value(input int lvl);
        int n;
        n = $urandom_range(0, 3);
        case ((lvl >= 3) ? $urandom_range(2, 3) : $urandom_range(0, 3))
            0: begin
                pend_bytes.push_back(CH_LBRACE);
                for (int i = 0; i < n; i++) begin
                    if (i > 0) pend_bytes.push_back(CH_COMMA);
                    add_string();
                    pend_bytes.push_back(CH_COLON);
                    add_value(lvl + 1);
                end
                pend_bytes.push_back(CH_RBRACE);
            end
            1: begin
                pend_bytes.push_back(CH_LBRACKET);
                for (int i = 0; i < n; i++) begin
                    if (i > 0) pend_bytes.push_back(CH_COMMA);
                    add_value(lvl + 1);
                end
                pend_bytes.push_back(CH_RBRACKET);
            end
            2: add_string();
            default: begin
                repeat (n + 1) pend_bytes.push_back(8'(CH_DIGIT0 + $urandom_range(0, 9)));
            end
        endcase
    endtask

    initial begin
        #8_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int kind;
        int pos;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty buffer alone, then one-byte buffers open and plain
        send_req(8'hA5, 1'b1, 1'b1);
        pend_bytes.push_back(CH_LBRACE);
        send_buffer();
        pend_bytes.push_back(8'hFF);
        send_buffer();
        // balanced document, then a byte after the answer
        pend_bytes.push_back(CH_LBRACE);
        pend_bytes.push_back(CH_RBRACE);
        pend_bytes.push_back(CH_LF);
        pend_bytes.push_back(8'h7A);
        send_buffer();
        // line break before any byte
        pend_bytes.push_back(CH_LF);
        pend_bytes.push_back(8'h7A);
        send_buffer();
        // zero byte ends the scan even inside a string
        pend_bytes.push_back(CH_QUOTE);
        pend_bytes.push_back(CH_NUL);
        pend_bytes.push_back(8'hFF);
        send_buffer();
        // buffer ending on a backslash
        pend_bytes.push_back(CH_BSLASH);
        send_buffer();
        // carriage return as the marked last byte
        pend_bytes.push_back(CH_LBRACKET);
        pend_bytes.push_back(CH_RBRACKET);
        pend_bytes.push_back(CH_CR);
        send_buffer();
        pend_bytes.push_back(CH_RBRACE);
        send_buffer();
        // empty buffer abandons a partial scan
        send_req(CH_LBRACE, 1'b0, 1'b0);
        send_req(CH_NUL, 1'b1, 1'b1);
        // line break and escaped quote inside a string, then a stray close
        pend_bytes.push_back(CH_QUOTE);
        pend_bytes.push_back(CH_LF);
        pend_bytes.push_back(CH_BSLASH);
        pend_bytes.push_back(CH_QUOTE);
        pend_bytes.push_back(CH_QUOTE);
        pend_bytes.push_back(CH_RBRACKET);
        send_buffer();

        while (item_count < ITEM_TARGET) begin
            quiet = (item_count >= ITEM_TARGET - 300) || ($urandom_range(0, 7) == 0);
            kind  = $urandom_range(0, 19);
            if (kind == 17) begin
                send_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            end else begin
                if (kind < 14 || kind > 17) begin
                    add_value(0);
                    if (kind >= 12 && kind < 14) begin
                        pos = $urandom_range(0, pend_bytes.size() - 1);
                        if ($urandom_range(0, 1)) pend_bytes.delete(pos);
                        else pend_bytes.insert(pos, pick_noise());
                        if (pend_bytes.size() == 0) pend_bytes.push_back(pick_noise());
                    end
                    if ($urandom_range(0, 3) != 0) begin
                        pend_bytes.push_back(pick_terminator());
                        repeat ($urandom_range(0, 3)) pend_bytes.push_back(pick_noise());
                    end
                end else if (kind == 14) begin
                    pend_bytes.push_back(pick_terminator());
                    repeat ($urandom_range(0, 4)) pend_bytes.push_back(pick_noise());
                end else begin
                    repeat ($urandom_range(1, 24)) pend_bytes.push_back(pick_noise());
                end
                send_buffer();
            end
        end
        quiet = 1'b1;
        i_valid <= 1'b0;

        do @(posedge i_clk); while (pending_docs != 0);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
